// ===== hdl/timestamp_slot_table_assert.svh =====
// Assertion macros used by the timestamp slot table top level.
`ifndef TIMESTAMP_SLOT_TABLE_ASSERT_SVH
`define TIMESTAMP_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tst_pkg.sv =====
// Package with item types, command and status codes for the timestamp slot table.
package tst_pkg;

  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int SLOT_SPAN = 16;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ELAPSED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [TIME_W-1:0]   elapsed_ms;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;        // an item is taken this cycle
    logic load_direct;   // result of this item is ready now
    logic load_elapsed;  // stamp read has returned, form the elapsed result
  } ctl_t;

endpackage

// ===== hdl/tst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tst_ctrl.sv =====
// Controller state machine: input and output handshake and datapath sequencing.
module tst_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [tst_pkg::CMD_W-1:0] in_cmd,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tst_pkg::ctl_t         ctl
);
  import tst_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, direct, elapsed_cmd;

  assign in_stall    = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept      = in_valid && !in_stall;
  assign elapsed_cmd = (in_cmd == CMD_ELAPSED);
  assign direct      = (in_cmd == CMD_RESERVE) || (in_cmd == CMD_UPDATE) ||
                       (in_cmd == CMD_REMOVE);

  assign ctl.accept       = accept;
  assign ctl.load_direct  = accept && direct;
  assign ctl.load_elapsed = (state_r == S_READ);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept && direct) begin
          out_valid_nxt = 1'b1;
        end
        if (accept && elapsed_cmd) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/tst_dp.sv =====
// Datapath: millisecond counter, in-use bits, stamp memory and result register.
module tst_dp #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tst_pkg::ctl_t      ctl,
  input  tst_pkg::in_item_t  in_item,
  output tst_pkg::out_item_t out_item
);
  import tst_pkg::*;

  localparam int AW = $clog2(SLOTS);

  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SLOTS-1:0]  in_use_r, in_use_nxt;
  out_item_t         out_r, out_nxt;
  logic              live_r, live_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [TIME_W-1:0] ram_rdata;

  logic [SLOT_W-1:0] idx;
  logic [AW-1:0]     addr;
  logic              in_range;
  logic              live;
  logic              found;
  logic [AW-1:0]     grant;

  assign idx      = in_item.slot_in;
  assign addr     = idx[AW-1:0];
  assign in_range = ({1'b0, idx} < (SLOT_W+1)'(SLOTS));
  assign live     = in_range && in_use_r[addr];

  // Lowest free slot.
  always_comb begin
    found = 1'b0;
    grant = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found = 1'b1;
        grant = AW'(i);
      end
    end
  end

  tst_ram #(
    .WIDTH(TIME_W),
    .DEPTH(SLOTS)
  ) u_stamp_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(now_r),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    now_nxt    = now_r;
    in_use_nxt = in_use_r;
    out_nxt    = out_r;
    live_nxt   = live_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = addr;

    if (ctl.accept) begin
      live_nxt = live;
      idx_nxt  = idx;
      unique case (in_item.cmd)
        CMD_TICK: begin
          now_nxt = now_r + 1'b1;
        end
        CMD_RESERVE: begin
          if (found) begin
            in_use_nxt[grant] = 1'b1;
            ram_we            = 1'b1;
            ram_waddr         = grant;
            out_nxt           = '{slot_out: SLOT_W'(grant), elapsed_ms: '0, status: ST_OK};
          end else begin
            out_nxt = '{slot_out: '0, elapsed_ms: '0, status: ST_FULL};
          end
        end
        CMD_UPDATE: begin
          ram_we  = live;
          out_nxt = '{slot_out: idx, elapsed_ms: '0, status: live ? ST_OK : ST_UNUSED};
        end
        CMD_REMOVE: begin
          if (live) begin
            in_use_nxt[addr] = 1'b0;
          end
          out_nxt = '{slot_out: idx, elapsed_ms: '0, status: live ? ST_OK : ST_UNUSED};
        end
        default: begin
        end
      endcase
    end

    if (ctl.load_elapsed) begin
      out_nxt.slot_out   = idx_r;
      out_nxt.elapsed_ms = live_r ? (now_r - ram_rdata) : '0;
      out_nxt.status     = live_r ? ST_OK : ST_UNUSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      in_use_r <= '0;
    end else begin
      now_r    <= now_nxt;
      in_use_r <= in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    live_r <= live_nxt;
    idx_r  <= idx_nxt;
  end

  assign out_item = out_r;

endmodule

// ===== hdl/timestamp_slot_table.sv =====
// Timestamp slot table: timing, reset and throughput of the top level follow.
// A tick item is taken and gives no result item.
// Reserve, update and remove items give their result in the cycle after acceptance.
// An elapsed item holds off input while the stamp memory is read, then loads the result.
// Throughput: one item per cycle for tick, reserve, update and remove while out_stall is low.
// Reset clears the counter and all in-use bits at once; stamps are written before they are read.
module timestamp_slot_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tst_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tst_pkg::out_item_t out_item
);
  import tst_pkg::*;

  // Only the first sixteen slots can be named by the four-bit slot fields, so the
  // table holds no more than that; larger settings behave as a sixteen-slot table.
  localparam int USABLE = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;

  ctl_t ctl;

  // The controller owns the handshake. It takes a new item whenever the result
  // register is empty or is being emptied in the same cycle, and holds off input while
  // the stamp memory returns the word an elapsed query needs.
  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctl      (ctl)
  );

  // The datapath keeps the millisecond counter, the in-use bits and the stamp
  // memory, finds the lowest free slot on reserve and forms the result item.
  tst_dp #(
    .SLOTS(USABLE)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_item (in_item),
    .out_item(out_item)
  );

`include "timestamp_slot_table_assert.svh"

  // An accepted elapsed query must hold off the next item while the stamp is read.
  `TST_ASSERT_NEXT(a_elapsed_holds, in_valid && !in_stall && in_item.cmd == CMD_ELAPSED, in_stall, "elapsed query did not hold off input")
  // A tick never produces a result item.
  `TST_ASSERT_NEXT(a_tick_silent, in_valid && !in_stall && in_item.cmd == CMD_TICK && !out_valid, !out_valid, "tick produced a result")
  // Any failing result carries a zero elapsed time.
  `TST_ASSERT_NOW(a_fail_zero, out_valid && out_item.status != ST_OK, out_item.elapsed_ms == '0, "failed result with nonzero elapsed time")
  // A full table reports slot zero.
  `TST_ASSERT_NOW(a_full_slot, out_valid && out_item.status == ST_FULL, out_item.slot_out == '0, "full table result with nonzero slot")

endmodule
